@@ hdl/aape_pkg.sv @@
package aape_pkg;

    // Printable offset added to every 6-bit slice and checksum half.
    localparam logic [7:0] CHAR_OFFSET = 8'd61;

    // Character positions within the work of one item.
    localparam int NUM_STEPS = 9;
    localparam logic [3:0] STEP_START = 4'd0;
    localparam logic [3:0] STEP_TYPE  = 4'd1;
    localparam logic [3:0] STEP_G0    = 4'd2;
    localparam logic [3:0] STEP_G1    = 4'd3;
    localparam logic [3:0] STEP_G2    = 4'd4;
    localparam logic [3:0] STEP_G3    = 4'd5;
    localparam logic [3:0] STEP_CK_HI = 4'd6;
    localparam logic [3:0] STEP_CK_LO = 4'd7;
    localparam logic [3:0] STEP_END   = 4'd8;

    // Queue depth between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Work for the back: which character groups one item produces.
    typedef struct packed {
        logic       hdr;
        logic [7:0] type_code;
        logic       grp;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic       trl;
    } job_t;

endpackage

@@ hdl/aape_front.sv @@
module aape_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      data_byte,
    input  logic [7:0]      type_code,
    input  logic            first_byte,
    input  logic            last_byte,
    input  logic            q_full,
    output logic            push,
    output aape_pkg::job_t  push_job
);

    logic [1:0] fill_reg, fill_next;
    logic [7:0] hi_reg, hi_next;
    logic [7:0] lo_reg, lo_next;
    logic [1:0] fill_eff;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // A first mark drops any open group before this byte is placed.
    assign fill_eff = first_byte ? 2'd0 : fill_reg;

    // Classify the item: header, full or flushed group, trailer.
    always_comb begin
        fill_next          = fill_reg;
        hi_next            = hi_reg;
        lo_next            = lo_reg;
        push_job.hdr       = first_byte;
        push_job.type_code = type_code;
        push_job.grp       = 1'b0;
        push_job.byte_a    = hi_reg;
        push_job.byte_b    = lo_reg;
        push_job.byte_c    = data_byte;
        push_job.trl       = last_byte;
        unique case (fill_eff)
            2'd0: begin
                hi_next         = data_byte;
                fill_next       = last_byte ? 2'd0 : 2'd1;
                push_job.grp    = last_byte;
                push_job.byte_a = data_byte;
                push_job.byte_b = 8'd0;
                push_job.byte_c = 8'd0;
            end
            2'd1: begin
                lo_next         = data_byte;
                fill_next       = last_byte ? 2'd0 : 2'd2;
                push_job.grp    = last_byte;
                push_job.byte_b = data_byte;
                push_job.byte_c = 8'd0;
            end
            default: begin
                fill_next    = 2'd0;
                push_job.grp = 1'b1;
            end
        endcase
    end

    // Items that produce no character update the group and push nothing.
    assign push = accept && (push_job.hdr || push_job.grp || push_job.trl);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
            hi_reg   <= 8'd0;
            lo_reg   <= 8'd0;
        end else if (accept) begin
            fill_reg <= fill_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
    end

endmodule

@@ hdl/aape_queue.sv @@
module aape_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  aape_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output aape_pkg::job_t  head_job
);

    localparam int AW = aape_pkg::QUEUE_AW;

    aape_pkg::job_t entry_reg [aape_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(aape_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hdl/aape_back.sv @@
module aape_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      open_tag,
    input  logic [7:0]      end_tag,
    input  logic            head_valid,
    input  aape_pkg::job_t  head_job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      frame_char,
    output logic            frame_end
);

    localparam int NS = aape_pkg::NUM_STEPS;

    logic [NS-1:0] done_reg, done_next;
    logic [NS-1:0] enable;
    logic [NS-1:0] remain;
    logic [NS-1:0] cur_hot;
    logic [3:0]    cur_step;
    logic [11:0]   sum_reg, sum_next;
    logic          valid_reg;
    logic [7:0]    char_reg;
    logic          end_reg;
    logic [7:0]    char_val;
    logic [5:0]    slice;
    logic          issue;

    // Steps this job produces, in output order.
    assign enable = {{3{head_job.trl}}, {4{head_job.grp}}, {2{head_job.hdr}}};
    assign remain = enable & ~done_reg;

    // Lowest step still to be issued.
    always_comb begin
        cur_step = 4'd0;
        cur_hot  = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (remain[i]) begin
                cur_step = 4'(i);
                cur_hot  = NS'(1) << i;
            end
        end
    end

    assign issue = head_valid && (!valid_reg || out_ready);
    assign pop   = issue && ((remain & ~cur_hot) == '0);

    // Character for the current step and the running checksum.
    always_comb begin
        slice    = 6'd0;
        char_val = 8'd0;
        sum_next = sum_reg;
        unique case (cur_step)
            aape_pkg::STEP_START: begin
                char_val = open_tag;
                sum_next = {4'd0, open_tag};
            end
            aape_pkg::STEP_TYPE: begin
                char_val = head_job.type_code;
                sum_next = sum_reg + {4'd0, char_val};
            end
            aape_pkg::STEP_G0: begin
                slice    = head_job.byte_a[7:2];
                char_val = aape_pkg::CHAR_OFFSET + {2'd0, slice};
                sum_next = sum_reg + {4'd0, char_val};
            end
            aape_pkg::STEP_G1: begin
                slice    = {head_job.byte_a[1:0], head_job.byte_b[7:4]};
                char_val = aape_pkg::CHAR_OFFSET + {2'd0, slice};
                sum_next = sum_reg + {4'd0, char_val};
            end
            aape_pkg::STEP_G2: begin
                slice    = {head_job.byte_b[3:0], head_job.byte_c[7:6]};
                char_val = aape_pkg::CHAR_OFFSET + {2'd0, slice};
                sum_next = sum_reg + {4'd0, char_val};
            end
            aape_pkg::STEP_G3: begin
                slice    = head_job.byte_c[5:0];
                char_val = aape_pkg::CHAR_OFFSET + {2'd0, slice};
                sum_next = sum_reg + {4'd0, char_val};
            end
            aape_pkg::STEP_CK_HI: begin
                char_val = aape_pkg::CHAR_OFFSET + {2'd0, sum_reg[11:6]};
            end
            aape_pkg::STEP_CK_LO: begin
                char_val = aape_pkg::CHAR_OFFSET + {2'd0, sum_reg[5:0]};
            end
            aape_pkg::STEP_END: begin
                char_val = end_tag;
                sum_next = 12'd0;
            end
            default: begin
                char_val = 8'd0;
            end
        endcase
    end

    assign done_next = pop ? '0 : (done_reg | cur_hot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            sum_reg   <= 12'd0;
            valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                done_reg <= done_next;
                sum_reg  <= sum_next;
            end
            if (issue) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output register: loaded when the queue holds a job and the register is empty or being drained.
    always_ff @(posedge aclk) begin
        if (issue) begin
            char_reg <= char_val;
            end_reg  <= (cur_step == aape_pkg::STEP_END);
        end
    end

    assign out_valid  = valid_reg;
    assign frame_char = char_reg;
    assign frame_end  = end_reg;

endmodule

@@ hdl/ascii_armor_packet_encoder_top.sv @@
// Printable packet frame encoder.
// The s_ channel takes one payload byte per item: s_tdata carries the byte and
// the packet type, s_tuser marks the first byte and s_tlast the last byte.
// The m_ channel gives one frame character per item, with m_tlast on the end
// tag. A frame is the start tag, the type byte, four characters for every three
// payload bytes (a partial group is zero padded on the last byte), two checksum
// characters and the end tag. Tags are set through the register port.
// The back emits one character per cycle from its output register while m_tready
// is high and the queue holds work; an item produces none to nine characters,
// four per three bytes inside a packet. Input items are taken in consecutive
// cycles while the four-entry work queue has room; with the queue and the output
// register empty, an item's first character passes through the queue entry and
// then the output register before it is shown.
// A stall on m_tready holds the output character and, once the queue fills,
// drops s_tready. Reset empties the queue, clears the open group and the
// checksum, and sets both tags to zero.
module ascii_armor_packet_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] type_code
    input  logic [0:0]  s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    // Result item.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_char
    output logic        m_tlast,   // frame_end
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           q_full;
    logic           push;
    aape_pkg::job_t push_job;
    logic           pop;
    logic           head_valid;
    aape_pkg::job_t head_job;
    logic [7:0]     open_tag_reg;
    logic [7:0]     end_tag_reg;
    logic           cfg_write;

    // Register port: start tag at 0, end tag at 4.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_tag_reg <= 8'd0;
            end_tag_reg  <= 8'd0;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                end_tag_reg <= pwdata[7:0];
            end else begin
                open_tag_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'd0, paddr[2] ? end_tag_reg : open_tag_reg};

    aape_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata[7:0]),
        .type_code  (s_tdata[15:8]),
        .first_byte (s_tuser[0]),
        .last_byte  (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    aape_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    aape_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .open_tag   (open_tag_reg),
        .end_tag    (end_tag_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .frame_char (m_tdata),
        .frame_end  (m_tlast)
    );

endmodule
